FILE: rtl/core/tne_pkg.sv
// Shared types, constants and helpers for the torus neighbor enumerator.
package tne_pkg;

   // Design constants.
   localparam int MAX_DIMS   = 3;   // torus dimensions supported, 1 to 3
   localparam int COORD_BITS = 8;   // bits of one coordinate, 1 to 8

   // Field widths fixed by the interface.
   localparam int ID_W          = 24;
   localparam int CFG_DIMS      = 3;
   localparam int SIZE_FIELD_W  = 9;
   localparam int COUNT_FIELD_W = 2;
   localparam int DIST_W        = 2;
   localparam int REG_IDX_W     = 3;

   // Derived widths.
   localparam int SIZE_W     = COORD_BITS + 1;
   localparam int DIM_W      = $clog2(MAX_DIMS + 1);
   localparam int DIM_IDX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int MULT_W     = COORD_BITS * (MAX_DIMS - 1) + 1;

   // Divider: quotient bits retired per cycle, and divider steps per dimension.
   localparam int DIV_BITS   = 3;
   localparam int DIV_CYCLES = ID_W / DIV_BITS;
   localparam int STEP_W     = $clog2(DIV_CYCLES);

   // Queue between front and back, a power of two.
   localparam int QUEUE_DEPTH = 2;

   // Per-dimension choice: coordinate minus one, unchanged, plus one.
   localparam int CHOICES = 3;
   localparam int CH_W    = 2;
   localparam logic [CH_W-1:0] CH_MINUS = 2'd0;
   localparam logic [CH_W-1:0] CH_SAME  = 2'd1;
   localparam logic [CH_W-1:0] CH_PLUS  = 2'd2;

   // Register indexes of the control port.
   localparam logic [REG_IDX_W-1:0] REG_DIM_COUNT    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM0    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM1    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SIZE_DIM2    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_DISTANCE = 3'd4;

   // Register reset values.
   localparam logic [COUNT_FIELD_W-1:0] RESET_DIM_COUNT = 2'd3;
   localparam logic [SIZE_FIELD_W-1:0]  RESET_SIZE      = 9'd4;
   localparam logic [DIST_W-1:0]        RESET_MAX_DIST  = 2'd1;

   typedef struct packed {
      logic [COUNT_FIELD_W-1:0]                  dim_count;
      logic [CFG_DIMS-1:0][SIZE_FIELD_W-1:0]     size;
      logic [DIST_W-1:0]                         max_distance;
   } cfg_type;

   // One prepared node: for every dimension and choice, the coordinate
   // already weighted by the product of the lower extents.
   typedef struct packed {
      logic [MAX_DIMS-1:0][CHOICES-1:0][ID_W-1:0] term;
      logic [DIM_W-1:0]                           dims;
      logic [DIST_W-1:0]                          max_dist;
   } job_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_MUL,
      F_PUSH
   } front_state_type;

   // A zero extent counts as one, an extent above the coordinate range saturates.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_FIELD_W-1:0] s);
      logic [SIZE_W-1:0] r;
      if (s == '0) begin
         r = SIZE_W'(1);
      end else if (s > SIZE_FIELD_W'(1 << COORD_BITS)) begin
         r = SIZE_W'(1 << COORD_BITS);
      end else begin
         r = SIZE_W'(s);
      end
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] eff_dims(input logic [COUNT_FIELD_W-1:0] n);
      logic [DIM_W-1:0] r;
      if (n > COUNT_FIELD_W'(MAX_DIMS)) begin
         r = DIM_W'(MAX_DIMS);
      end else begin
         r = DIM_W'(n);
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/tne_front.sv
// Front part: accepts a node id, splits it into coordinates and weights them.
module tne_front
   import tne_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [ID_W-1:0] node_id,
   input  cfg_type         cfg,
   input  logic            queue_full,
   output logic            push,
   output job_type         job
);

   front_state_type         state_ff, state_in;
   logic [DIM_IDX_W-1:0]    dim_ff, dim_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [ID_W-1:0]         quo_ff, quo_in;
   logic [COORD_BITS-1:0]   rem_ff, rem_in;
   logic [MULT_W-1:0]       mult_ff, mult_in;
   job_type                 job_ff, job_in;

   logic [SIZE_W-1:0]       size_sel;
   logic [ID_W-1:0]         div_quo;
   logic [COORD_BITS-1:0]   div_rem;
   logic [COORD_BITS-1:0]   c_minus, c_plus;
   logic [COORD_BITS+MULT_W-1:0] p_minus, p_same, p_plus;
   logic [MULT_W+SIZE_W-1:0]     p_mult;
   logic [DIM_W-1:0]        dims_done;
   logic                    dim_last;

   assign size_sel  = clamp_size(cfg.size[dim_ff]);
   assign dims_done = DIM_W'(dim_ff) + DIM_W'(1);
   assign dim_last  = (dims_done == job_ff.dims);

   // Restoring division, DIV_BITS quotient bits per cycle.
   always_comb begin
      logic [SIZE_W-1:0]     trial;
      logic [COORD_BITS-1:0] r;
      logic [ID_W-1:0]       q;
      r = rem_ff;
      q = quo_ff;
      trial = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {r, q[ID_W-1]};
         q = {q[ID_W-2:0], 1'b0};
         if (trial >= size_sel) begin
            trial = trial - size_sel;
            q[0] = 1'b1;
         end
         r = trial[COORD_BITS-1:0];
      end
      div_quo = q;
      div_rem = r;
   end

   // Wrapping neighbors of the coordinate and their weighted terms.
   always_comb begin
      logic [SIZE_W-1:0] top;
      top = size_sel - SIZE_W'(1);
      c_minus = (rem_ff == '0) ? top[COORD_BITS-1:0] : rem_ff - COORD_BITS'(1);
      c_plus  = (SIZE_W'(rem_ff) >= top) ? '0 : rem_ff + COORD_BITS'(1);
      p_minus = {{MULT_W{1'b0}}, c_minus} * {{COORD_BITS{1'b0}}, mult_ff};
      p_same  = {{MULT_W{1'b0}}, rem_ff}  * {{COORD_BITS{1'b0}}, mult_ff};
      p_plus  = {{MULT_W{1'b0}}, c_plus}  * {{COORD_BITS{1'b0}}, mult_ff};
      p_mult  = {{SIZE_W{1'b0}}, mult_ff} * {{MULT_W{1'b0}}, size_sel};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               state_in = (eff_dims(cfg.dim_count) == '0) ? F_PUSH : F_DIV;
            end
         end
         F_DIV: begin
            if (step_ff == STEP_W'(DIV_CYCLES - 1)) begin
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            state_in = dim_last ? F_PUSH : F_DIV;
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_tready = (state_ff == F_IDLE);
      push       = (state_ff == F_PUSH) && !queue_full;
   end

   // Datapath.
   always_comb begin
      dim_in  = dim_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      mult_in = mult_ff;
      job_in  = job_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               quo_in          = node_id;
               rem_in          = '0;
               step_in         = '0;
               dim_in          = '0;
               mult_in         = MULT_W'(1);
               job_in.term     = '0;
               job_in.dims     = eff_dims(cfg.dim_count);
               job_in.max_dist = cfg.max_distance;
            end
         end
         F_DIV: begin
            quo_in  = div_quo;
            rem_in  = div_rem;
            step_in = step_ff + STEP_W'(1);
         end
         F_MUL: begin
            job_in.term[dim_ff][CH_MINUS] = p_minus[ID_W-1:0];
            job_in.term[dim_ff][CH_SAME]  = p_same[ID_W-1:0];
            job_in.term[dim_ff][CH_PLUS]  = p_plus[ID_W-1:0];
            mult_in = p_mult[MULT_W-1:0];
            rem_in  = '0;
            step_in = '0;
            dim_in  = dim_ff + DIM_IDX_W'(1);
         end
         F_PUSH: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dim_ff  <= dim_in;
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      mult_ff <= mult_in;
      job_ff  <= job_in;
   end

   assign job = job_ff;

endmodule

FILE: rtl/core/tne_queue.sv
// Short queue of prepared nodes between the front and the back part.
module tne_queue
   import tne_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    head_valid
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   job_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

FILE: rtl/core/tne_back.sv
// Back part: walks the neighbor choices in depth-first order and emits ids.
module tne_back
   import tne_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   input  job_type         job,
   output logic            pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [ID_W-1:0] neighbor_id,
   output logic            rsp_tlast
);

   logic                          active_ff, active_in;
   logic [MAX_DIMS-1:0][CH_W-1:0] ch_ff, ch_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]               rsp_id_ff, rsp_id_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [DIM_W-1:0]              acc;
   logic                          emit_ok;
   logic                          final_vec;
   logic                          last_vec;
   logic [ID_W-1:0]               id_sum;
   logic [MAX_DIMS-1:0][CH_W-1:0] ch_step;
   logic [MAX_DIMS-1:0][CH_W-1:0] ch_start;
   logic                          out_free;
   logic                          stall;

   // Classify the current choice vector. Dimensions not in use stay unchanged.
   always_comb begin
      logic in_use;
      logic carry;
      acc       = '0;
      final_vec = 1'b1;
      last_vec  = 1'b1;
      id_sum    = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         in_use = (DIM_W'(d) < job.dims);
         if (ch_ff[d] != CH_SAME) begin
            acc = acc + DIM_W'(1);
         end
         if (in_use && (ch_ff[d] != CH_PLUS)) begin
            final_vec = 1'b0;
         end
         // The last result varies the lowest dimensions upward as far as allowed.
         if (ch_ff[d] != ((in_use && (DIST_W'(d) < job.max_dist)) ? CH_PLUS : CH_SAME)) begin
            last_vec = 1'b0;
         end
         id_sum      = id_sum + job.term[d][ch_ff[d]];
         ch_start[d] = in_use ? CH_MINUS : CH_SAME;
      end
      if (job.max_dist == '0) begin
         emit_ok = (acc == '0);
      end else begin
         emit_ok = (acc != '0) && (DIST_W'(acc) <= job.max_dist);
      end
      // Odometer step, the highest dimension in use turns fastest.
      ch_step = ch_ff;
      carry   = 1'b1;
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         if ((DIM_W'(d) < job.dims) && carry) begin
            if (ch_ff[d] == CH_PLUS) begin
               ch_step[d] = CH_MINUS;
            end else begin
               ch_step[d] = ch_ff[d] + CH_W'(1);
               carry      = 1'b0;
            end
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign stall    = emit_ok && !out_free;

   always_comb begin
      active_in    = active_ff;
      ch_in        = ch_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      if (!active_ff) begin
         if (job_valid) begin
            active_in = 1'b1;
            ch_in     = ch_start;
         end
      end else if (!stall) begin
         if (emit_ok) begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = id_sum;
            rsp_last_in  = last_vec;
         end
         if (final_vec) begin
            pop       = 1'b1;
            active_in = 1'b0;
         end else begin
            ch_in = ch_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign neighbor_id = rsp_id_ff;
   assign rsp_tlast   = rsp_last_ff;

   a_walk_has_job: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> job_valid)
      else $error("neighbor walk running without a queued node");

endmodule

FILE: rtl/core/torus_neighbor_enumerator_unit.sv
// Top level of the torus neighbor enumerator: control registers and the two halves.
//
// The unit takes one node id per word on the req_ channel and returns the ids
// of its torus neighbors on the rsp_ channel, one id per word, in depth-first
// order (per dimension: coordinate minus one, unchanged, plus one, with
// wrap-around), with rsp_tlast set on the last id of each node. A node gives
// at most 26 words; with max_distance 0 it gives its own id, and with no
// dimensions in use and a nonzero distance it gives none. Duplicates that come
// from extents of one or two are kept. The front part splits the id into
// coordinates with a restoring divider that retires three quotient bits per
// cycle, then weights the coordinates of each dimension. The back part loads
// a node and walks all 3^dims choice vectors, one per cycle while the output
// is not stalled. A two-entry queue sits between the parts, so the front
// prepares the next node while the back still emits the previous one;
// sustained throughput is set by the slower part. The result word sits in an
// output register, and the walk only pauses while that register is full and
// not being taken. Control registers are written on the csr_ channel, which
// is always ready; they must only change while the unit is idle. Indexes
// beyond the register list are ignored.
module torus_neighbor_enumerator_unit
   import tne_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Request channel, one node per word.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ID_W-1:0]         req_tdata,    // [23:0] node_id
   // Response channel, one neighbor per word.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [ID_W-1:0]         rsp_tdata,    // [23:0] neighbor_id
   output logic                    rsp_tlast,
   // Control register writes.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [REG_IDX_W-1:0]    csr_index,
   input  logic [SIZE_FIELD_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    head_valid;
   job_type front_job;
   job_type head_job;

   // The register file accepts a write in every cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DIM_COUNT:    cfg_in.dim_count    = csr_data[COUNT_FIELD_W-1:0];
            REG_SIZE_DIM0:    cfg_in.size[0]      = csr_data;
            REG_SIZE_DIM1:    cfg_in.size[1]      = csr_data;
            REG_SIZE_DIM2:    cfg_in.size[2]      = csr_data;
            REG_MAX_DISTANCE: cfg_in.max_distance = csr_data[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_count    <= RESET_DIM_COUNT;
         cfg_ff.size         <= {CFG_DIMS{RESET_SIZE}};
         cfg_ff.max_distance <= RESET_MAX_DIST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: coordinate split and weighting.
   tne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .node_id    (req_tdata),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .job        (front_job)
   );

   tne_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (front_job),
      .full       (queue_full),
      .pop        (pop),
      .head       (head_job),
      .head_valid (head_valid)
   );

   // Back: depth-first walk and result register.
   tne_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (head_valid),
      .job         (head_job),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .neighbor_id (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

FILE: sim/neighbor_list_checker.sv
// Checker for the torus neighbor enumerator: predicts the neighbor words and compares them.
`timescale 1ns / 100ps
module neighbor_list_checker
   import tne_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [ID_W-1:0]         req_tdata,    // [23:0] node_id
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [ID_W-1:0]         rsp_tdata,    // [23:0] neighbor_id
   input  logic                    rsp_tlast,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [REG_IDX_W-1:0]    csr_index,
   input  logic [SIZE_FIELD_W-1:0] csr_data,
   output int                      fail_count,
   output int                      words_pending
);

   localparam int TOP_EXTENT   = 1 << COORD_BITS;

   typedef struct packed {
      logic [ID_W-1:0] neighbor_id;
      logic            last;
   } neighbor_word_type;

   neighbor_word_type        expected_words[$];
   logic [COUNT_FIELD_W-1:0] dim_count_reg;
   logic [SIZE_FIELD_W-1:0]  extent_reg[MAX_DIMS];
   logic [DIST_W-1:0]        distance_reg;

   initial begin
      fail_count    = 0;
      words_pending = 0;
   end

   function automatic void report(input string what, input logic [ID_W-1:0] want,
                                  input logic [ID_W-1:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
   endfunction

   // Choice vectors are counted with dimension zero as the most significant digit, so
   // counting order is the depth-first order. A vector stands for one emitted neighbor
   // only if every dimension after the point where the walk stops is left unchanged.
   function automatic void enumerate_neighbors(input logic [ID_W-1:0] node);
      int                span[MAX_DIMS];
      int                coord[MAX_DIMS];
      logic [CH_W-1:0]   pick[MAX_DIMS];
      int                dims, limit, combos, rest, varied, stop, moved, d, k, v;
      longint unsigned   divisor, weight, rebuilt;
      logic [ID_W-1:0]   found[$];
      bit                settled;
      neighbor_word_type entry;
      dims    = (dim_count_reg > MAX_DIMS) ? MAX_DIMS : int'(dim_count_reg);
      limit   = int'(distance_reg);
      divisor = 1;
      combos  = 1;
      for (d = 0; d < MAX_DIMS; d++) begin
         if (extent_reg[d] == 0) begin
            span[d] = 1;
         end else if (extent_reg[d] > TOP_EXTENT) begin
            span[d] = TOP_EXTENT;
         end else begin
            span[d] = int'(extent_reg[d]);
         end
         coord[d] = 0;
         pick[d]  = CH_SAME;
      end
      for (d = 0; d < dims; d++) begin
         coord[d] = int'((node / divisor) % span[d]);
         divisor  = divisor * span[d];
         combos   = combos * CHOICES;
      end
      for (v = 0; v < combos; v++) begin
         rest = v;
         for (k = dims - 1; k >= 0; k--) begin
            pick[k] = CH_W'(rest % CHOICES);
            rest    = rest / CHOICES;
         end
         varied = 0;
         stop   = dims;
         for (k = 0; k < dims; k++) begin
            if (stop == dims && varied == limit) begin
               stop = k;
            end
            if (stop == dims && pick[k] != CH_SAME) begin
               varied++;
            end
         end
         settled = (varied == limit) || (varied > 0);
         for (k = stop; k < dims; k++) begin
            if (pick[k] != CH_SAME) begin
               settled = 1'b0;
            end
         end
         if (settled) begin
            rebuilt = 0;
            weight  = 1;
            for (k = 0; k < dims; k++) begin
               moved = coord[k];
               if (k < stop && pick[k] == CH_MINUS) begin
                  moved = (coord[k] == 0) ? span[k] - 1 : coord[k] - 1;
               end else if (k < stop && pick[k] == CH_PLUS) begin
                  moved = (coord[k] >= span[k] - 1) ? 0 : coord[k] + 1;
               end
               rebuilt = rebuilt + moved * weight;
               weight  = weight * span[k];
            end
            found = {found, rebuilt[ID_W-1:0]};
         end
      end
      for (k = 0; k < found.size(); k++) begin
         entry.neighbor_id = found[k];
         entry.last        = (k == found.size() - 1);
         expected_words    = {expected_words, entry};
      end
   endfunction

   always @(posedge clock) begin : monitor
      neighbor_word_type want;
      if (reset) begin
         dim_count_reg = RESET_DIM_COUNT;
         for (int d = 0; d < MAX_DIMS; d++) begin
            extent_reg[d] = RESET_SIZE;
         end
         distance_reg = RESET_MAX_DIST;
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: word with no expectation, expected none actual %h",
                        $time, rsp_tdata);
            end else begin
               want = expected_words.pop_front();
               if (want.neighbor_id !== rsp_tdata) begin
                  report("neighbor_id", want.neighbor_id, rsp_tdata);
               end
               if (want.last !== rsp_tlast) begin
                  report("last", ID_W'(want.last), ID_W'(rsp_tlast));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            enumerate_neighbors(req_tdata);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DIM_COUNT:    dim_count_reg = csr_data[COUNT_FIELD_W-1:0];
               REG_SIZE_DIM0:    extent_reg[0] = csr_data;
               REG_SIZE_DIM1:    extent_reg[1] = csr_data;
               REG_SIZE_DIM2:    extent_reg[2] = csr_data;
               REG_MAX_DISTANCE: distance_reg  = csr_data[DIST_W-1:0];
               default: ;
            endcase
         end
      end
      words_pending = expected_words.size();
   end

endmodule

FILE: sim/torus_neighbor_enumerator_unit_test.sv
// Testbench top for the torus neighbor enumerator: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module torus_neighbor_enumerator_unit_test;
   import tne_pkg::*;

   // Cycles to let the block finish nodes that give no word before touching the
   // registers: up to a node in the front, two queued and one in the back.
   localparam int SETTLE_CYCLES    = 150;
   // The long hold-off on the response side, long enough to back up the queue.
   localparam int SINK_HOLD_CYCLES = 600;
   localparam int END_LIMIT_CYCLES = 20000;
   localparam int PHASES           = 10;
   localparam int PHASE_ITEMS      = 34;
   localparam int TOP_EXTENT       = 1 << COORD_BITS;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ID_W-1:0]         req_tdata  = '0;      // [23:0] node_id
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [ID_W-1:0]         rsp_tdata;            // [23:0] neighbor_id
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [REG_IDX_W-1:0]    csr_index  = '0;
   logic [SIZE_FIELD_W-1:0] csr_data   = '0;

   int          fail_count;
   int          words_pending;
   // Random idling on both channels; cleared for some phases to get back-to-back traffic.
   bit          idle_on     = 1'b1;
   // The stimulus bumps hold_req to ask the response side for one long hold-off.
   int          hold_req    = 0;
   int          hold_served = 0;
   // Number of nodes on the torus as currently configured, used to aim the node ids.
   int unsigned node_span   = 64;

   always #10 clock = ~clock;

   torus_neighbor_enumerator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   neighbor_list_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   // Idle stretches are mostly short, with an occasional long one.
   function automatic int pick_gap();
      int gap;
      if ($urandom_range(0, 9) == 0) begin
         gap = $urandom_range(20, 60);
      end else begin
         gap = $urandom_range(1, 3);
      end
      return gap;
   endfunction

   // Extents cover the clamping cases (zero, above the coordinate range) as well as
   // the duplicate-producing sizes one and two.
   function automatic int pick_extent();
      int ext;
      case ($urandom_range(0, 7))
         0:       ext = 0;
         1:       ext = 1;
         2:       ext = 2;
         3:       ext = TOP_EXTENT;
         4:       ext = $urandom_range(TOP_EXTENT + 1, 511);
         default: ext = $urandom_range(3, TOP_EXTENT - 1);
      endcase
      return ext;
   endfunction

   // Most ids land on the torus; the rest are corners and ids that fold back.
   function automatic logic [ID_W-1:0] pick_node();
      logic [ID_W-1:0] node;
      case ($urandom_range(0, 7))
         0:       node = '0;
         1:       node = ID_W'(node_span - 1);
         2:       node = '1;
         3:       node = ID_W'($urandom);
         default: node = ID_W'($urandom_range(0, node_span - 1));
      endcase
      return node;
   endfunction

   // Offers one node and returns at the edge where it is taken. The valid is left
   // high unless a gap is drawn, so consecutive nodes can go back to back.
   task automatic send_node(input logic [ID_W-1:0] node);
      req_tvalid <= 1'b1;
      req_tdata  <= node;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // Stops offering nodes and waits until every predicted word has come back, then
   // lets the block run out any node that gives no word at all.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The valid stays high from one register write to the next; the caller lowers it
   // after the last one.
   task automatic write_reg(input logic [REG_IDX_W-1:0] index,
                            input logic [SIZE_FIELD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Writes all five registers while the block is idle. The two-bit registers get
   // random upper data bits, which the block must drop, and one write goes to an
   // index past the register list, which the block must ignore.
   task automatic configure(input int dims, input int ext0, input int ext1, input int ext2,
                            input int reach);
      int ext[MAX_DIMS];
      int d;
      ext[0] = ext0;
      ext[1] = ext1;
      ext[2] = ext2;
      wait_drained();
      write_reg(REG_DIM_COUNT,
                (SIZE_FIELD_W'($urandom) & ~SIZE_FIELD_W'(3)) | SIZE_FIELD_W'(dims));
      write_reg(REG_SIZE_DIM0, SIZE_FIELD_W'(ext0));
      write_reg(REG_SIZE_DIM1, SIZE_FIELD_W'(ext1));
      write_reg(REG_SIZE_DIM2, SIZE_FIELD_W'(ext2));
      write_reg(REG_MAX_DISTANCE,
                (SIZE_FIELD_W'($urandom) & ~SIZE_FIELD_W'(3)) | SIZE_FIELD_W'(reach));
      write_reg(REG_MAX_DISTANCE + REG_IDX_W'($urandom_range(1, 3)),
                SIZE_FIELD_W'($urandom));
      csr_valid <= 1'b0;
      node_span = 1;
      for (d = 0; d < dims && d < MAX_DIMS; d++) begin
         node_span = node_span * ((ext[d] == 0) ? 1 :
                                  (ext[d] > TOP_EXTENT) ? TOP_EXTENT : ext[d]);
      end
   endtask

   // Response side. Readiness changes once per edge at most. When the stimulus asks
   // for the long hold-off, ready is held low while the request side keeps
   // offering nodes, so the queue fills and req_tready drops.
   initial begin : response_sink
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_served != hold_req) begin
            rsp_tready <= 1'b0;
            repeat (SINK_HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int phase, item, items, dims, reach;
      int ext[MAX_DIMS];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First the reset setting: a 4x4x4 torus, one dimension varies.
      send_node(ID_W'(0));
      send_node(ID_W'(63));
      send_node(ID_W'(42));
      send_node('1);                          // far beyond the torus, folds back
      // Distance zero gives the node's own id.
      configure(3, 4, 4, 4, 0);
      send_node(ID_W'(5));
      send_node(ID_W'(24'h800000));
      // Extents of one and two give duplicate neighbors; every dimension varies.
      configure(3, 1, 2, 3, 3);
      send_node(ID_W'(0));
      send_node(ID_W'(5));
      // No dimensions: distance zero gives id zero, any other distance nothing.
      configure(0, 4, 4, 4, 0);
      send_node(ID_W'(24'hABCDEF));
      configure(0, 4, 4, 4, 2);
      send_node(ID_W'(7));
      // A zero extent counts as one, extents past the coordinate range saturate.
      configure(3, 0, TOP_EXTENT + 1, 511, 2);
      send_node(ID_W'(24'h5A5A5A));
      send_node(ID_W'(0));
      // Distance above the dimension count: neighbors come at the last dimension.
      configure(1, TOP_EXTENT, 4, 4, 3);
      send_node(ID_W'(10));
      send_node(ID_W'(TOP_EXTENT - 1));
      configure(2, TOP_EXTENT, TOP_EXTENT, 1, 2);
      send_node(ID_W'(24'h00FFFF));
      send_node(ID_W'(24'h123456));
      // Largest torus, most words per node.
      configure(3, TOP_EXTENT, TOP_EXTENT, TOP_EXTENT, 3);
      send_node('1);
      send_node(ID_W'(0));

      // Random part, one register setting per phase.
      for (phase = 0; phase < PHASES; phase++) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            ext[d] = pick_extent();
         end
         dims  = $urandom_range(1, 3);
         reach = $urandom_range(0, 3);
         items = PHASE_ITEMS;
         case (phase)
            0: begin
               dims  = 3;
               reach = 3;
               for (int d = 0; d < MAX_DIMS; d++) begin
                  ext[d] = TOP_EXTENT;
               end
            end
            1: begin
               dims   = 3;
               reach  = 2;
               ext[0] = 1;
               ext[1] = 2;
               ext[2] = 3;
            end
            2: begin
               // Nodes give no word here, so only a handful of them.
               dims  = 0;
               reach = $urandom_range(1, 3);
               items = 6;
            end
            4: begin
               dims  = 3;
               reach = 2;
            end
            default: ;
         endcase
         idle_on = (phase % 4 != 3);
         configure(dims, ext[0], ext[1], ext[2], reach);
         if (phase == 4) begin
            hold_req++;
         end
         for (item = 0; item < items; item++) begin
            if (phase == 5 && item == items / 2) begin
               wait_drained();
            end
            send_node(pick_node());
         end
      end

      // Let everything come back, with a bound, then wait out the settle time to catch
      // any stray word.
      req_tvalid <= 1'b0;
      @(posedge clock);
      for (item = 0; item < END_LIMIT_CYCLES && words_pending != 0; item++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (words_pending != 0) begin
         $display("%0t: %0d expected neighbor words never arrived", $time, words_pending);
      end
      if (fail_count == 0 && words_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest correct run.
   initial begin : watchdog
      #50ms;
      $display("status: fail");
      $finish;
   end

endmodule
